// ===== rtl/wmcd_pkg.sv =====
// ----------------------------------------------------------------------------
// wmcd_pkg
// Shared types and constants of the watermark crossing detector.
// ----------------------------------------------------------------------------
package wmcd_pkg;

  localparam int COUNT_W        = 16;
  localparam int NUM_MARK_REGS  = 3;
  localparam int MARKS_PER_SIDE = 3;
  localparam int MARK_IDX_W     = 2;
  localparam int MASK_W         = 3;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 16;
  localparam int IN_TDATA_W     = 32;
  localparam int OUT_TDATA_W    = 24;
  localparam int OUT_FIELDS_W   = 1 + MARK_IDX_W + COUNT_W;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_MARK_A   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_MARK_B   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_MARK_C   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_MARK_A    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_MARK_B    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_MARK_C    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_ENABLE   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_ENABLE    = 4'd7;

  localparam logic SIDE_RISING  = 1'b0;
  localparam logic SIDE_FALLING = 1'b1;

  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    count_t [NUM_MARK_REGS-1:0] high_mark;
    count_t [NUM_MARK_REGS-1:0] low_mark;
    logic [MASK_W-1:0]          high_en;
    logic [MASK_W-1:0]          low_en;
  } wmcd_cfg_t;

  typedef struct packed {
    logic                  found;
    logic                  side;
    logic [MARK_IDX_W-1:0] index;
  } wmcd_hit_t;

endpackage

// ===== rtl/wmcd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// wmcd_cfg_regs
// Threshold and enable registers written through the configuration channel.
// ----------------------------------------------------------------------------
module wmcd_cfg_regs
  import wmcd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output wmcd_cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HIGH_MARK_A: cfg.high_mark[0] <= cfg_data;
        REG_HIGH_MARK_B: cfg.high_mark[1] <= cfg_data;
        REG_HIGH_MARK_C: cfg.high_mark[2] <= cfg_data;
        REG_LOW_MARK_A:  cfg.low_mark[0]  <= cfg_data;
        REG_LOW_MARK_B:  cfg.low_mark[1]  <= cfg_data;
        REG_LOW_MARK_C:  cfg.low_mark[2]  <= cfg_data;
        REG_HIGH_ENABLE: cfg.high_en      <= cfg_data[MASK_W-1:0];
        REG_LOW_ENABLE:  cfg.low_en       <= cfg_data[MASK_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

endmodule

// ===== rtl/wmcd_select.sv =====
// ----------------------------------------------------------------------------
// wmcd_select
// Picks the nearest enabled mark on the active side and checks the crossing.
// ----------------------------------------------------------------------------
module wmcd_select
  import wmcd_pkg::*;
(
  input  wmcd_cfg_t cfg,
  input  count_t    new_count,
  input  count_t    current_count,
  input  count_t    last_count,
  output wmcd_hit_t hit
);

  logic                  hi_found;
  logic                  lo_found;
  count_t                hi_best;
  count_t                lo_best;
  logic [MARK_IDX_W-1:0] hi_pick;
  logic [MARK_IDX_W-1:0] lo_pick;

  // strict compares keep the lowest index among equal levels
  always_comb begin
    hi_found = 1'b0;
    lo_found = 1'b0;
    hi_best  = '0;
    lo_best  = '0;
    hi_pick  = '0;
    lo_pick  = '0;
    for (int i = 0; i < MARKS_PER_SIDE; i++) begin
      if (cfg.high_en[i] && cfg.high_mark[i] <= new_count &&
          (!hi_found || cfg.high_mark[i] > hi_best)) begin
        hi_found = 1'b1;
        hi_best  = cfg.high_mark[i];
        hi_pick  = MARK_IDX_W'(i);
      end
      if (cfg.low_en[i] && cfg.low_mark[i] >= new_count &&
          (!lo_found || cfg.low_mark[i] < lo_best)) begin
        lo_found = 1'b1;
        lo_best  = cfg.low_mark[i];
        lo_pick  = MARK_IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (new_count < current_count) begin
      hit.side  = SIDE_FALLING;
      hit.index = lo_pick;
      hit.found = lo_found && (last_count > lo_best);
    end else begin
      hit.side  = SIDE_RISING;
      hit.index = hi_pick;
      hit.found = hi_found && (last_count < hi_best);
    end
  end

endmodule

// ===== rtl/watermark_crossing_detector.sv =====
// ----------------------------------------------------------------------------
// watermark_crossing_detector
// Reports when a queue count crosses an enabled high or low watermark.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one count update per transfer: new_count and current_count.
//   m_axis carries one notification per crossing: side, mark index, new count.
//   an update that crosses no mark produces no transfer on m_axis.
//   cfg writes the six mark levels and two enable masks; write only while idle.
// timing:
//   one update per cycle while m_axis is not stalled; an update is held in the
//   input register, is evaluated against the marks and the stored last count,
//   and its notification is then loaded into the output register, which drives
//   m_axis.
//   the last-count register updates in the same cycle as the evaluation, so
//   back-to-back updates see each other with no bubble.
// reset and stall:
//   rst clears marks, masks, last count and both valid flags.
//   while m_axis holds a notification and m_axis_tready is low the pipeline
//   holds; s_axis_tready drops once the input register is also full.
// ----------------------------------------------------------------------------
module watermark_crossing_detector
  import wmcd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // new_count, current_count
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // mark_side, mark_index, reported_count, zero pad
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  wmcd_cfg_t cfg;
  wmcd_hit_t hit;

  logic   in_valid;
  count_t in_new;
  count_t in_cur;
  count_t last_count;

  logic                  out_valid;
  logic                  out_side;
  logic [MARK_IDX_W-1:0] out_index;
  count_t                out_count;

  logic advance;

  assign cfg_ready     = 1'b1;
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  wmcd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wmcd_select u_sel (
    .cfg           (cfg),
    .new_count     (in_new),
    .current_count (in_cur),
    .last_count    (last_count),
    .hit           (hit)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_new <= s_axis_tdata[COUNT_W-1:0];
      in_cur <= s_axis_tdata[2*COUNT_W-1:COUNT_W];
    end
  end

  // evaluation and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      last_count <= '0;
    end else if (advance) begin
      out_valid <= in_valid && hit.found;
      if (in_valid) begin
        last_count <= in_new;
      end
    end
    if (advance && in_valid) begin
      out_side  <= hit.side;
      out_index <= hit.index;
      out_count <= in_new;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_count, out_index, out_side};

endmodule

// ===== rtl/wmcd_checker.sv =====
// ----------------------------------------------------------------------------
// wmcd_checker
// Port-level checks of the watermark crossing detector, bound to the top.
// ----------------------------------------------------------------------------
module wmcd_checker
  import wmcd_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // a stalled notification keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled notification changed");

  // no notification right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("notification valid after reset");

  // mark index stays within the marks of a side
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[MARK_IDX_W:1] != 2'b11)
    else $error("mark index out of range");

  // with the output register empty the input side never stalls
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind watermark_crossing_detector wmcd_checker u_wmcd_checker (.*);

// ===== bench/watermark_crossing_detector_test.sv =====
// ----------------------------------------------------------------------------
// watermark_crossing_detector_test
// Drives count updates into the detector, keeps a local copy of the mark
// registers and of the last count, predicts every crossing notification and
// compares each one that leaves m_axis. Covers reset state, tie breaks,
// extreme levels, single enables, output backpressure and random traffic
// around the configured marks.
// ----------------------------------------------------------------------------
module watermark_crossing_detector_test;
  import wmcd_pkg::*;

  localparam int COUNT_MAX      = (1 << COUNT_W) - 1;
  localparam int PIPE_DRAIN     = 4;
  localparam int RX_HOLD_CYCLES = 150;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_UPDATES  = 95;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = REG_LOW_ENABLE + 4'd1;

  typedef struct packed {
    logic                  side;
    logic [MARK_IDX_W-1:0] index;
    count_t                count;
  } crossing_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // new_count, current_count
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // mark_side, mark_index, reported_count, zero pad
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // local copy of the detector registers and state
  count_t            hi_level [NUM_MARK_REGS];
  count_t            lo_level [NUM_MARK_REGS];
  logic [MASK_W-1:0] hi_enable;
  logic [MASK_W-1:0] lo_enable;
  count_t            last_count;

  crossing_t crossings_due [$];
  crossing_t due;
  crossing_t seen;

  bit tx_idle     = 1'b0;
  bit rx_idle     = 1'b0;
  bit rx_hold_req = 1'b0;

  int errors      = 0;
  int updates     = 0;
  int reg_writes  = 0;
  int rising_hits = 0;
  int falling_hits = 0;
  int quiet       = 0;

  watermark_crossing_detector i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic count_t clamp_count(input int v);
    if (v < 0) return '0;
    if (v > COUNT_MAX) return count_t'(COUNT_MAX);
    return count_t'(v);
  endfunction

  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void reset_marks();
    for (int i = 0; i < NUM_MARK_REGS; i++) begin
      hi_level[i] = '0;
      lo_level[i] = '0;
    end
    hi_enable  = '0;
    lo_enable  = '0;
    last_count = '0;
  endfunction

  function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    if (idx <= REG_HIGH_MARK_C) begin
      hi_level[idx - REG_HIGH_MARK_A] = data[COUNT_W-1:0];
    end else if (idx <= REG_LOW_MARK_C) begin
      lo_level[idx - REG_LOW_MARK_A] = data[COUNT_W-1:0];
    end else if (idx == REG_HIGH_ENABLE) begin
      hi_enable = data[MASK_W-1:0];
    end else if (idx == REG_LOW_ENABLE) begin
      lo_enable = data[MASK_W-1:0];
    end
    // writes to unused indexes leave everything as is
  endfunction

  // falling path: smallest enabled low mark at or above the new count
  // rising path: largest enabled high mark at or below it
  function automatic void predict_crossing(input count_t nc, input count_t cc);
    crossing_t hit;
    logic      found;
    int        pick;
    found = 1'b0;
    pick  = 0;
    if (nc < cc) begin
      hit.side = SIDE_FALLING;
      for (int i = 0; i < NUM_MARK_REGS; i++) begin
        if (i < MARKS_PER_SIDE && lo_enable[i] && lo_level[i] >= nc &&
            (!found || lo_level[i] < lo_level[pick])) begin
          pick  = i;
          found = 1'b1;
        end
      end
      if (found && !(last_count > lo_level[pick])) found = 1'b0;
    end else begin
      hit.side = SIDE_RISING;
      for (int i = 0; i < NUM_MARK_REGS; i++) begin
        if (i < MARKS_PER_SIDE && hi_enable[i] && hi_level[i] <= nc &&
            (!found || hi_level[i] > hi_level[pick])) begin
          pick  = i;
          found = 1'b1;
        end
      end
      if (found && !(last_count < hi_level[pick])) found = 1'b0;
    end
    last_count = nc;
    if (found) begin
      hit.index = pick[MARK_IDX_W-1:0];
      hit.count = nc;
      crossings_due.push_back(hit);
    end
  endfunction

  task automatic send_update(input count_t nc, input count_t cc);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {cc, nc};
    do @(posedge clk); while (!s_axis_tready);
    predict_crossing(nc, cc);
    updates++;
    gap = tx_idle ? gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic stop_input();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (crossings_due.size() != 0) @(posedge clk);
    // updates without a crossing may still be in the pipe
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    store_reg(idx, data);
    reg_writes++;
  endtask

  task automatic load_marks(input count_t [NUM_MARK_REGS-1:0] hm,
                            input count_t [NUM_MARK_REGS-1:0] lm,
                            input logic [MASK_W-1:0] he,
                            input logic [MASK_W-1:0] le);
    logic [CFG_DATA_W-1:0] noisy;
    stop_input();
    wait_idle();
    for (int i = 0; i < NUM_MARK_REGS; i++) begin
      write_reg(REG_HIGH_MARK_A + CFG_IDX_W'(i), hm[i]);
      write_reg(REG_LOW_MARK_A + CFG_IDX_W'(i), lm[i]);
    end
    // junk above the mask bits must be dropped
    noisy = CFG_DATA_W'($urandom);
    noisy[MASK_W-1:0] = he;
    write_reg(REG_HIGH_ENABLE, noisy);
    noisy = CFG_DATA_W'($urandom);
    noisy[MASK_W-1:0] = le;
    write_reg(REG_LOW_ENABLE, noisy);
    write_reg(CFG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 7)), CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic count_t near_mark();
    int pick;
    int level;
    pick  = $urandom_range(0, 2 * NUM_MARK_REGS - 1);
    level = (pick < NUM_MARK_REGS) ? int'(hi_level[pick])
                                   : int'(lo_level[pick - NUM_MARK_REGS]);
    level = level + $urandom_range(0, 8) - 4;
    return clamp_count(level);
  endfunction

  function automatic count_t random_new_count();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return count_t'($urandom);
    if (roll == 1) return $urandom_range(0, 1) ? count_t'(COUNT_MAX) : count_t'(0);
    return near_mark();
  endfunction

  function automatic count_t random_cur_count(input count_t nc);
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 9) return clamp_count(int'(nc) + $urandom_range(1, 300));
    if (roll < 16) return clamp_count(int'(nc) - $urandom_range(1, 300));
    if (roll < 18) return nc;
    return count_t'($urandom);
  endfunction

  // nothing enabled after reset: no update may cross
  task automatic test_reset_state();
    send_update('0, '0);
    send_update(count_t'(COUNT_MAX), '0);
    send_update('0, count_t'(COUNT_MAX));
    send_update(count_t'(COUNT_MAX), count_t'(COUNT_MAX));
  endtask

  task automatic test_tie_break();
    load_marks({16'd400, 16'd400, 16'd400}, {16'd200, 16'd200, 16'd200}, 3'b111, 3'b111);
    send_update(16'd0, 16'd1);
    send_update(16'd500, 16'd0);
    load_marks({16'd400, 16'd400, 16'd400}, {16'd200, 16'd200, 16'd200}, 3'b110, 3'b110);
    send_update(16'd0, 16'd500);
    send_update(16'd500, 16'd0);
  endtask

  task automatic test_extremes();
    load_marks({16'd32768, 16'd0, 16'hffff}, {16'd32768, 16'hffff, 16'd0}, 3'b111, 3'b111);
    send_update(16'hffff, 16'hffff);
    send_update(16'd0, 16'hffff);
    send_update(16'd0, 16'd0);
    send_update(16'd32768, 16'd0);
    send_update(16'd32767, 16'd32768);
    send_update(16'hffff, 16'd1);
  endtask

  task automatic test_single_enables();
    for (int i = 0; i < MARKS_PER_SIDE; i++) begin
      load_marks({16'd300, 16'd200, 16'd100}, {16'd50, 16'd150, 16'd250},
                 3'b001 << i, 3'b001 << i);
      send_update(16'd1000, 16'd0);
      send_update(16'd0, 16'd1000);
    end
  endtask

  // output held off while every update crosses, so the pipe fills up
  task automatic test_backpressure();
    load_marks({16'd0, 16'd0, 16'd1000}, {16'd0, 16'd0, 16'd500}, 3'b001, 3'b001);
    tx_idle     = 1'b0;
    rx_idle     = 1'b0;
    rx_hold_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_update(16'd2000, 16'd0);
      send_update(16'd100, 16'd2000);
    end
  endtask

  task automatic test_random_traffic();
    count_t [NUM_MARK_REGS-1:0] hm;
    count_t [NUM_MARK_REGS-1:0] lm;
    logic [MASK_W-1:0]          he;
    logic [MASK_W-1:0]          le;
    int                         base;
    int                         spread;
    count_t                     nc;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 6)
        0: spread = 0;
        1: spread = 20;
        default: spread = COUNT_MAX;
      endcase
      base = (spread == COUNT_MAX) ? 0 : $urandom_range(0, COUNT_MAX);
      he   = MASK_W'($urandom_range(0, 7));
      le   = MASK_W'($urandom_range(0, 7));
      for (int i = 0; i < NUM_MARK_REGS; i++) begin
        hm[i] = clamp_count(base + $urandom_range(0, spread));
        lm[i] = clamp_count(base + $urandom_range(0, spread));
      end
      if (phase % 6 == 4) begin
        hm = '0;
        lm = '0;
        he = '1;
        le = '1;
      end else if (phase % 6 == 5) begin
        hm = '1;
        lm = '1;
        he = '1;
        le = '1;
      end
      load_marks(hm, lm, he, le);
      tx_idle = (phase % 4 == 0) || (phase % 4 == 2);
      rx_idle = (phase % 4 == 0) || (phase % 4 == 1);
      for (int n = 0; n < PHASE_UPDATES; n++) begin
        nc = random_new_count();
        send_update(nc, random_cur_count(nc));
      end
    end
  endtask

  // receiver: random stalls, or one long hold-off on request
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else begin
        stall = rx_idle ? gap_len() : 0;
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.side  = m_axis_tdata[0];
      seen.index = m_axis_tdata[MARK_IDX_W:1];
      seen.count = m_axis_tdata[MARK_IDX_W+COUNT_W:MARK_IDX_W+1];
      if (crossings_due.size() == 0) begin
        $error("unexpected crossing: side %0d index %0d count %0d",
               seen.side, seen.index, seen.count);
        errors++;
      end else begin
        due = crossings_due.pop_front();
        if (seen.side != due.side) begin
          $error("mark_side: expected %0d, got %0d", due.side, seen.side);
          errors++;
        end
        if (seen.index != due.index) begin
          $error("mark_index: expected %0d, got %0d", due.index, seen.index);
          errors++;
        end
        if (seen.count != due.count) begin
          $error("reported_count: expected %0d, got %0d", due.count, seen.count);
          errors++;
        end
      end
      if (seen.side == SIDE_RISING) rising_hits++;
      else falling_hits++;
    end
  end

  // ends the run when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == WATCHDOG_LIMIT) begin
      $display("no transfer for %0d cycles, %0d crossings outstanding",
               WATCHDOG_LIMIT, crossings_due.size());
      $display("watermark_crossing_detector test failed");
      $finish;
    end
  end

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    reset_marks();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    test_reset_state();
    test_tie_break();
    test_extremes();
    test_single_enables();
    test_backpressure();
    test_random_traffic();
    stop_input();
    wait_idle();
    $display("%0d count updates and %0d register writes sent", updates, reg_writes);
    $display("%0d rising and %0d falling crossings checked, %0d mismatches",
             rising_hits, falling_hits, errors);
    if (errors == 0) begin
      $display("watermark_crossing_detector test passed");
    end else begin
      $display("watermark_crossing_detector test failed");
    end
    $finish;
  end

endmodule
